>>> rtl/core/gbn_pkg.sv
// Shared types, codes and a helper function for the Go-Back-N sender.
// Used by every module under rtl/core; has no dependencies of its own.
package gbn_pkg;

    localparam int BUFFER_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int LIM_W        = ((CNT_W > 7) ? CNT_W : 7) + 1;
    localparam int MAX_WINDOW   = 64;
    localparam int WIN_RESET    = 8;
    localparam int BSUM_W       = 13;
    localparam int PAYLOAD_W    = 160;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;

    // Event codes, equal to the func encoding at the input.
    localparam logic [1:0] OP_MSG   = 2'd0;
    localparam logic [1:0] OP_ACK   = 2'd1;
    localparam logic [1:0] OP_TMO   = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_TIMER = 2'd1;
    localparam logic [1:0] KIND_DROP  = 2'd2;

    localparam logic [1:0] TCMD_NONE    = 2'd0;
    localparam logic [1:0] TCMD_START   = 2'd1;
    localparam logic [1:0] TCMD_STOP    = 2'd2;
    localparam logic [1:0] TCMD_RESTART = 2'd3;

    // One classified event on its way from the front end to the back end.
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] ack;
        logic [63:0] p1;
        logic [63:0] p2;
        logic [31:0] p3;
    } gbn_cmd_t;

    // Sum of the 20 payload bytes, each read as unsigned.
    function automatic logic [BSUM_W-1:0] byte_sum(input logic [63:0] a,
                                                   input logic [63:0] b,
                                                   input logic [31:0] c);
        logic [BSUM_W-1:0] s;
        s = '0;
        for (int i = 0; i < 8; i++)
        begin
            s = s + BSUM_W'(a[8*i +: 8]) + BSUM_W'(b[8*i +: 8]);
        end
        for (int i = 0; i < 4; i++)
        begin
            s = s + BSUM_W'(c[8*i +: 8]);
        end
        return s;
    endfunction

endpackage

>>> rtl/core/gbn_front.sv
// Front end of the Go-Back-N sender: takes input transfers, checks ack
// checksums and pushes the surviving events into the command queue. Uses gbn_pkg.
module gbn_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            func,
    input  logic signed [31:0]    pkt_seq,
    input  logic signed [31:0]    pkt_ack,
    input  logic signed [31:0]    pkt_checksum,
    input  logic [63:0]           payload_first,
    input  logic [63:0]           payload_second,
    input  logic [31:0]           payload_third,
    output logic                  push_valid,
    input  logic                  push_ready,
    output gbn_pkg::gbn_cmd_t     push_cmd
);

    logic                       fr_valid_reg;
    logic [1:0]                 fr_op_reg;
    logic [31:0]                fr_ack_reg;
    logic [31:0]                fr_chk_reg;
    logic [31:0]                fr_partial_reg;
    logic [gbn_pkg::BSUM_W-1:0] fr_bsum_reg;
    logic [63:0]                fr_p1_reg;
    logic [63:0]                fr_p2_reg;
    logic [31:0]                fr_p3_reg;

    logic sum_ok;
    logic needs_push;
    logic fr_done;
    logic accept;

    // The checksum covers seq + ack + payload bytes, modulo 2^32.
    assign sum_ok = (fr_partial_reg + 32'(fr_bsum_reg)) == fr_chk_reg;

    always_comb
    begin
        case (fr_op_reg)
            gbn_pkg::OP_MSG: needs_push = 1'b1;
            gbn_pkg::OP_TMO: needs_push = 1'b1;
            gbn_pkg::OP_ACK: needs_push = sum_ok;
            default:         needs_push = 1'b0;
        endcase
    end

    assign fr_done    = !needs_push || push_ready;
    assign in_stall   = fr_valid_reg && !fr_done;
    assign accept     = in_valid && !in_stall;
    assign push_valid = fr_valid_reg && needs_push;

    assign push_cmd.op  = fr_op_reg;
    assign push_cmd.ack = fr_ack_reg;
    assign push_cmd.p1  = fr_p1_reg;
    assign push_cmd.p2  = fr_p2_reg;
    assign push_cmd.p3  = fr_p3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
            fr_op_reg    <= gbn_pkg::OP_NONE;
        end
        else if (accept)
        begin
            fr_valid_reg <= 1'b1;
            fr_op_reg    <= func;
        end
        else if (fr_done)
        begin
            fr_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fr_ack_reg     <= $unsigned(pkt_ack);
            fr_chk_reg     <= $unsigned(pkt_checksum);
            fr_partial_reg <= $unsigned(pkt_seq) + $unsigned(pkt_ack);
            fr_bsum_reg    <= gbn_pkg::byte_sum(payload_first, payload_second,
                                                payload_third);
            fr_p1_reg      <= payload_first;
            fr_p2_reg      <= payload_second;
            fr_p3_reg      <= payload_third;
        end
    end

endmodule

>>> rtl/core/gbn_queue.sv
// Short command queue between the front and back ends of the sender.
// Holds gbn_pkg::gbn_cmd_t entries; uses gbn_pkg.
module gbn_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  gbn_pkg::gbn_cmd_t push_cmd,
    output logic              pop_valid,
    input  logic              pop,
    output gbn_pkg::gbn_cmd_t pop_cmd
);

    gbn_pkg::gbn_cmd_t          entry_reg [gbn_pkg::QUEUE_DEPTH];
    logic [gbn_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [gbn_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [gbn_pkg::QCNT_W-1:0] cnt_reg;
    logic                       do_push;
    logic                       do_pop;

    assign push_ready = cnt_reg != gbn_pkg::QCNT_W'(gbn_pkg::QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + gbn_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + gbn_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + gbn_pkg::QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - gbn_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/core/gbn_back.sv
// Back end of the sender: owns the message store, the window pointers and
// the output register, and carries out queued events. Uses gbn_pkg.
module gbn_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [6:0]        cfg_wr_data,
    input  logic              cmd_valid,
    output logic              cmd_pop,
    input  gbn_pkg::gbn_cmd_t cmd,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        kind,
    output logic [1:0]        timer_cmd,
    output logic [9:0]        out_seq,
    output logic [12:0]       out_checksum,
    output logic [63:0]       out_payload_first,
    output logic [63:0]       out_payload_second,
    output logic [31:0]       out_payload_third,
    output logic              last
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_ACK   = 3'd4;
    localparam logic [2:0] ST_DROP  = 3'd5;

    localparam int CW = gbn_pkg::CNT_W;
    localparam int LW = gbn_pkg::LIM_W;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] base_reg, base_next;
    logic [CW-1:0] nts_reg, nts_next;
    logic [CW-1:0] count_reg, count_next;
    logic [6:0]    wsize_reg;
    logic [31:0]   ack_reg, ack_next;

    logic [gbn_pkg::PAYLOAD_W-1:0] mem [gbn_pkg::BUFFER_DEPTH];
    logic [gbn_pkg::PAYLOAD_W-1:0] rdata_reg;
    logic                          mem_we;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg, out_kind_next;
    logic [1:0]  out_tcmd_reg, out_tcmd_next;
    logic [9:0]  out_seq_reg, out_seq_next;
    logic [12:0] out_csum_reg, out_csum_next;
    logic [63:0] out_p1_reg, out_p1_next;
    logic [63:0] out_p2_reg, out_p2_next;
    logic [31:0] out_p3_reg, out_p3_next;
    logic        out_last_reg, out_last_next;
    logic        out_load;

    logic [6:0]    w_eff;
    logic [LW-1:0] limit;
    logic [CW-1:0] nts_inc;
    logic          more_cur;
    logic          more_inc;
    logic          store_full;
    logic          ack_ok;
    logic [CW-1:0] ack_base;
    logic          out_free;
    logic [63:0]   rd_p1;
    logic [63:0]   rd_p2;
    logic [31:0]   rd_p3;
    logic [31:0]   seq_wide;
    logic [31:0]   csum_wide;

    always_comb
    begin
        if (wsize_reg == '0)
        begin
            w_eff = 7'd1;
        end
        else if (wsize_reg > 7'(gbn_pkg::MAX_WINDOW))
        begin
            w_eff = 7'(gbn_pkg::MAX_WINDOW);
        end
        else
        begin
            w_eff = wsize_reg;
        end
    end

    // A packet goes out while its number is inside the window and stored.
    assign limit    = LW'(base_reg) + LW'(w_eff);
    assign nts_inc  = nts_reg + CW'(1);
    assign more_cur = (LW'(nts_reg) < limit) && (nts_reg < count_reg)
                      && (LW'(nts_reg) < LW'(gbn_pkg::BUFFER_DEPTH));
    assign more_inc = (LW'(nts_inc) < limit) && (nts_inc < count_reg)
                      && (LW'(nts_inc) < LW'(gbn_pkg::BUFFER_DEPTH));

    assign store_full = count_reg == CW'(gbn_pkg::BUFFER_DEPTH);

    // An ack counts only for a packet already sent and at most one below the base.
    assign ack_ok   = (ack_reg < 32'(nts_reg))
                      && (({1'b0, ack_reg} + 33'd1) >= 33'(base_reg));
    assign ack_base = ack_reg[CW-1:0] + CW'(1);

    assign out_free = !out_valid_reg || !out_stall;

    assign rd_p1     = rdata_reg[159:96];
    assign rd_p2     = rdata_reg[95:32];
    assign rd_p3     = rdata_reg[31:0];
    assign seq_wide  = 32'(nts_reg);
    assign csum_wide = seq_wide + 32'(gbn_pkg::byte_sum(rd_p1, rd_p2, rd_p3));

    assign cmd_pop = (state_reg == ST_IDLE) && cmd_valid;
    assign mem_we  = cmd_pop && (cmd.op == gbn_pkg::OP_MSG) && !store_full;

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        nts_next       = nts_reg;
        count_next     = count_reg;
        ack_next       = ack_reg;
        out_load       = 1'b0;
        out_kind_next  = gbn_pkg::KIND_DATA;
        out_tcmd_next  = gbn_pkg::TCMD_NONE;
        out_seq_next   = '0;
        out_csum_next  = '0;
        out_p1_next    = '0;
        out_p2_next    = '0;
        out_p3_next    = '0;
        out_last_next  = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        gbn_pkg::OP_MSG:
                        begin
                            if (store_full)
                            begin
                                state_next = ST_DROP;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                                state_next = ST_CHECK;
                            end
                        end
                        gbn_pkg::OP_ACK:
                        begin
                            ack_next   = cmd.ack;
                            state_next = ST_ACK;
                        end
                        gbn_pkg::OP_TMO:
                        begin
                            nts_next   = base_reg;
                            state_next = ST_CHECK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                // The store read of nts_reg lands at this edge.
                state_next = more_cur ? ST_EMIT : ST_IDLE;
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_kind_next = gbn_pkg::KIND_DATA;
                    out_tcmd_next = (base_reg == nts_reg) ? gbn_pkg::TCMD_START
                                                          : gbn_pkg::TCMD_NONE;
                    out_seq_next  = seq_wide[9:0];
                    out_csum_next = csum_wide[12:0];
                    out_p1_next   = rd_p1;
                    out_p2_next   = rd_p2;
                    out_p3_next   = rd_p3;
                    out_last_next = !more_inc;
                    nts_next      = nts_inc;
                    state_next    = more_inc ? ST_READ : ST_IDLE;
                end
            end
            ST_ACK:
            begin
                if (!ack_ok)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_load      = 1'b1;
                    out_kind_next = gbn_pkg::KIND_TIMER;
                    out_tcmd_next = (ack_base == nts_reg) ? gbn_pkg::TCMD_STOP
                                                          : gbn_pkg::TCMD_RESTART;
                    base_next     = ack_base;
                    state_next    = ST_IDLE;
                end
            end
            ST_DROP:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_kind_next = gbn_pkg::KIND_DROP;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= '0;
            nts_reg       <= '0;
            count_reg     <= '0;
            wsize_reg     <= 7'(gbn_pkg::WIN_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            nts_reg       <= nts_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                wsize_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ack_reg <= ack_next;
        if (out_load)
        begin
            out_kind_reg <= out_kind_next;
            out_tcmd_reg <= out_tcmd_next;
            out_seq_reg  <= out_seq_next;
            out_csum_reg <= out_csum_next;
            out_p1_reg   <= out_p1_next;
            out_p2_reg   <= out_p2_next;
            out_p3_reg   <= out_p3_next;
            out_last_reg <= out_last_next;
        end
    end

    // Message store: one write port for new messages, one registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[gbn_pkg::ADDR_W-1:0]] <= {cmd.p1, cmd.p2, cmd.p3};
        end
        rdata_reg <= mem[nts_reg[gbn_pkg::ADDR_W-1:0]];
    end

    assign out_valid          = out_valid_reg;
    assign kind               = out_kind_reg;
    assign timer_cmd          = out_tcmd_reg;
    assign out_seq            = out_seq_reg;
    assign out_checksum       = out_csum_reg;
    assign out_payload_first  = out_p1_reg;
    assign out_payload_second = out_p2_reg;
    assign out_payload_third  = out_p3_reg;
    assign last               = out_last_reg;

endmodule

>>> rtl/core/go_back_n_sender.sv
// Top level of the Go-Back-N sender: front end, command queue and back end.
// Depends on gbn_pkg, gbn_front, gbn_queue and gbn_back.
//
// Go-Back-N sender with a 1024-entry message store. Each input transfer is a
// message, an ack or a timeout; the front end registers each event, checks the
// ack checksum and hands events through a two-entry queue to the back end,
// so new events are taken while earlier ones are still being sent. For each
// packet that a message or timeout sends, the back end first does the
// registered store read and then forms its checksum into the output register.
// An ack or a dropped message is handled in its own back-end state, ST_ACK or
// ST_DROP. The store has a single write port and a single read port
// and needs no clearing after reset, so the block is ready at once.
// The window size register may only be written while no event is in flight.
module go_back_n_sender (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          func,
    input  logic signed [31:0]  pkt_seq,
    input  logic signed [31:0]  pkt_ack,
    input  logic signed [31:0]  pkt_checksum,
    input  logic [63:0]         payload_first,
    input  logic [63:0]         payload_second,
    input  logic [31:0]         payload_third,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          kind,
    output logic [1:0]          timer_cmd,
    output logic [9:0]          out_seq,
    output logic [12:0]         out_checksum,
    output logic [63:0]         out_payload_first,
    output logic [63:0]         out_payload_second,
    output logic [31:0]         out_payload_third,
    output logic                last
);

    logic              push_valid;
    logic              push_ready;
    gbn_pkg::gbn_cmd_t push_cmd;
    logic              cmd_valid;
    logic              cmd_pop;
    gbn_pkg::gbn_cmd_t cmd;

    gbn_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .pkt_seq        (pkt_seq),
        .pkt_ack        (pkt_ack),
        .pkt_checksum   (pkt_checksum),
        .payload_first  (payload_first),
        .payload_second (payload_second),
        .payload_third  (payload_third),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_cmd       (push_cmd)
    );

    gbn_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (cmd_valid),
        .pop        (cmd_pop),
        .pop_cmd    (cmd)
    );

    gbn_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .cmd_valid          (cmd_valid),
        .cmd_pop            (cmd_pop),
        .cmd                (cmd),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .kind               (kind),
        .timer_cmd          (timer_cmd),
        .out_seq            (out_seq),
        .out_checksum       (out_checksum),
        .out_payload_first  (out_payload_first),
        .out_payload_second (out_payload_second),
        .out_payload_third  (out_payload_third),
        .last               (last)
    );

endmodule

>>> rtl/core/gbn_checker.sv
// Port-level checks for go_back_n_sender and the bind that attaches them.
// Uses gbn_pkg codes; watches only the top level's output channel.
module gbn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [1:0]  timer_cmd,
    input logic [9:0]  out_seq,
    input logic [12:0] out_checksum,
    input logic        last
);

    // A dropped message is reported alone, with no timer action.
    a_drop_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == gbn_pkg::KIND_DROP
        |-> last && timer_cmd == gbn_pkg::TCMD_NONE)
        else $error("drop result must be last and carry no timer command");

    // An accepted ack always stops the timer, possibly restarting it.
    a_ack_timer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == gbn_pkg::KIND_TIMER
        |-> last && (timer_cmd == gbn_pkg::TCMD_STOP
                     || timer_cmd == gbn_pkg::TCMD_RESTART))
        else $error("ack result must be last and stop the timer");

    // Data packets only ever start the timer.
    a_data_timer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == gbn_pkg::KIND_DATA
        |-> timer_cmd == gbn_pkg::TCMD_NONE || timer_cmd == gbn_pkg::TCMD_START)
        else $error("data packet with a stop timer command");

    // The checksum adds unsigned payload bytes to the sequence number.
    a_data_csum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == gbn_pkg::KIND_DATA |-> out_checksum >= 13'(out_seq))
        else $error("data checksum below its sequence number");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall
        |=> out_valid && $stable(kind) && $stable(out_seq) && $stable(last))
        else $error("stalled result changed");

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .timer_cmd    (timer_cmd),
    .out_seq      (out_seq),
    .out_checksum (out_checksum),
    .last         (last)
);
